@@ rtl/great_circle_bearing_top_assert.svh @@
// Assertion macros for the great-circle bearing block
`ifndef GREAT_CIRCLE_BEARING_TOP_ASSERT_SVH
`define GREAT_CIRCLE_BEARING_TOP_ASSERT_SVH

// a holds at an edge, so c holds at that edge
`define GCB_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("gcb check failed");

// a holds at an edge, so c holds after the delay n
`define GCB_ASSERT_DLY(lbl, a, n, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> ##n (c)) \
    else $error("gcb check failed");

`endif

@@ rtl/gcb_pkg.sv @@
// Package: types, constants and helper functions of the bearing pipeline
`default_nettype none
package gcb_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 24;

  localparam int unsigned XW = 34;  // rotation x/y
  localparam int unsigned ZW = 34;  // rotation angle
  localparam int unsigned QW = 36;  // Q30 products
  localparam int unsigned AW = 38;  // vectoring x/y

  localparam logic signed [34:0] TURN_E7      = 35'sd3600000000;
  localparam logic [62:0]        BAM_MUL      = 63'd1281023894;
  localparam logic [62:0]        BAM_RND      = 63'd536870912;
  localparam logic signed [XW-1:0] Q_ONE      = XW'(64'sd1073741824);
  localparam logic signed [XW-1:0] CORDIC_START = XW'(64'sd652032874);
  localparam logic [31:0]        QUARTER      = 32'h4000_0000;
  localparam logic [31:0]        HALF         = 32'h8000_0000;
  localparam logic [47:0]        DEG_SCALE    = 48'd36000;
  localparam logic [47:0]        OUT_RND      = 48'd2147483648;
  localparam logic [15:0]        FULL_TURN    = 16'd36000;

  typedef struct packed {
    logic                   valid;
    logic                   zero;
    logic                   neg;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [ZW-1:0]   z;
  } rot_t;

  typedef struct packed {
    logic                   valid;
    logic                   zero;
    logic signed [AW-1:0]   x;
    logic signed [AW-1:0]   y;
    logic [31:0]            z;
  } vec_t;

  function automatic logic [31:0] atan_bam(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;  1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;  3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;  9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;  11: r = 32'h000517CC;
      12: r = 32'h00028BE6;  13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;  15: r = 32'h0000517D;
      16: r = 32'h000028BE;  17: r = 32'h0000145F;
      18: r = 32'h00000A30;  19: r = 32'h00000518;
      20: r = 32'h0000028C;  21: r = 32'h00000146;
      22: r = 32'h000000A3;  23: r = 32'h00000051;
      24: r = 32'h00000029;  25: r = 32'h00000014;
      26: r = 32'h0000000A;  27: r = 32'h00000005;
      28: r = 32'h00000003;  29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // 1e-7 degree value into [0, 3.6e9)
  function automatic logic [31:0] reduce_turn(input logic signed [34:0] x);
    logic signed [34:0] r;
    if (x >= TURN_E7) begin
      r = x - TURN_E7;
    end else if (x >= 35'sd0) begin
      r = x;
    end else if (x >= -TURN_E7) begin
      r = x + TURN_E7;
    end else begin
      r = x + TURN_E7 + TURN_E7;
    end
    return r[31:0];
  endfunction

  // binary angle into CORDIC start vector, folded into the right half plane
  function automatic rot_t rot_prep(input logic [31:0] ang, input logic valid);
    rot_t        r;
    logic [31:0] q;
    logic [31:0] a;
    q       = ang + QUARTER;
    a       = q[31] ? ang + HALF : ang;
    r.valid = valid;
    r.zero  = (ang == 32'd0);
    r.neg   = q[31];
    r.x     = CORDIC_START;
    r.y     = '0;
    r.z     = ZW'($signed(a));
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/gcb_rot_cell.sv @@
// One rotation-mode CORDIC stage of the sine/cosine chain
`default_nettype none
module gcb_rot_cell #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire gcb_pkg::rot_t d_i,
  output gcb_pkg::rot_t     q_o
);

  gcb_pkg::rot_t q_q, q_d;
  logic signed [gcb_pkg::XW-1:0] dx, dy;
  logic signed [gcb_pkg::ZW-1:0] at;

  always_comb begin
    dx  = d_i.y >>> STAGE;
    dy  = d_i.x >>> STAGE;
    at  = gcb_pkg::ZW'(gcb_pkg::atan_bam(STAGE));
    q_d = d_i;
    if (d_i.z >= 0) begin
      q_d.x = d_i.x - dx;
      q_d.y = d_i.y + dy;
      q_d.z = d_i.z - at;
    end else begin
      q_d.x = d_i.x + dx;
      q_d.y = d_i.y - dy;
      q_d.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule
`default_nettype wire

@@ rtl/gcb_vec_cell.sv @@
// One vectoring-mode CORDIC stage of the atan2 chain
`default_nettype none
module gcb_vec_cell #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire gcb_pkg::vec_t d_i,
  output gcb_pkg::vec_t      q_o
);

  gcb_pkg::vec_t q_q, q_d;
  logic signed [gcb_pkg::AW-1:0] dx, dy;
  logic [31:0] at;

  always_comb begin
    dx  = d_i.y >>> STAGE;
    dy  = d_i.x >>> STAGE;
    at  = gcb_pkg::atan_bam(STAGE);
    q_d = d_i;
    if (d_i.y > 0) begin
      q_d.x = d_i.x + dx;
      q_d.y = d_i.y - dy;
      q_d.z = d_i.z + at;
    end else begin
      q_d.x = d_i.x - dx;
      q_d.y = d_i.y + dy;
      q_d.z = d_i.z - at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule
`default_nettype wire

@@ rtl/great_circle_bearing_top.sv @@
// Top level: initial great-circle bearing between two positions
//
// Command port: a transaction is taken when start_i is high and busy_o is low.
// busy_o is tied low; a new position pair may be given in every cycle.
// Inputs are latitude and longitude in 1e-7 degree; bearing_o is the initial
// course in hundredths of a degree, 0 to 35999, north 0, clockwise.
// Each result is shown for one cycle with done_o high, in input order.
// Throughput: one per cycle. The latency is set by the three rotation
// chains, which run in parallel, and the vectoring chain, one cell per stage
// each, plus angle reduction, the Q30 products and the final scaling.
// Reset clears all valid flags; no results appear until new transactions.
// The receiver cannot stall; results are never held back.
`default_nettype none
module great_circle_bearing_top #(
  parameter int unsigned CORDIC_STAGES = gcb_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic signed [30:0] from_lat_i,
  input  wire logic signed [31:0] from_lon_i,
  input  wire logic signed [30:0] to_lat_i,
  input  wire logic signed [31:0] to_lon_i,
  output logic                    done_o,
  output logic [15:0]             bearing_o
);

  localparam int unsigned N = CORDIC_STAGES;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, done_q;
  logic z4_q, z5_q, z6_q, z7_q, z8_q;

  logic signed [30:0] lat1_q, lat2_q;
  logic signed [32:0] dlon_q;
  logic [31:0]        r_q [3];
  logic [62:0]        p_q [3];
  logic [62:0]        pr  [3];
  logic [31:0]        ang [3];

  gcb_pkg::rot_t rc [3][N+1];
  gcb_pkg::vec_t vc [N+1];

  logic signed [gcb_pkg::XW-1:0] s_q [3];
  logic signed [gcb_pkg::XW-1:0] c_q [3];
  logic signed [gcb_pkg::XW-1:0] s_d [3];
  logic signed [gcb_pkg::XW-1:0] c_d [3];

  logic signed [2*gcb_pkg::XW-1:0] m_a1, m_c1s2, m_s1c2;
  logic signed [gcb_pkg::QW-1:0]   a1_5_q, c1s2_5_q, s1c2_5_q;
  logic signed [gcb_pkg::XW-1:0]   cd5_q;
  logic signed [gcb_pkg::QW+gcb_pkg::XW-1:0] m_t;
  logic signed [gcb_pkg::QW-1:0]   a1_6_q, c1s2_6_q, t6_q;
  logic signed [gcb_pkg::QW-1:0]   a1_7_q, a2_7_q, a2_6;

  logic [47:0] prod_q, rnd;
  logic [15:0] h, bearing_q;

  assign busy_o = 1'b0;

  // angle reduction and binary-angle conversion
  always_ff @(posedge clk_i) begin
    lat1_q <= from_lat_i;
    lat2_q <= to_lat_i;
    dlon_q <= 33'(to_lon_i) - 33'(from_lon_i);
    r_q[0] <= gcb_pkg::reduce_turn(35'(lat1_q));
    r_q[1] <= gcb_pkg::reduce_turn(35'(lat2_q));
    r_q[2] <= gcb_pkg::reduce_turn(35'(dlon_q));
    for (int k = 0; k < 3; k++) begin
      p_q[k] <= 63'(r_q[k]) * gcb_pkg::BAM_MUL;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_prep
    assign pr[k]    = p_q[k] + gcb_pkg::BAM_RND;
    assign ang[k]   = pr[k][61:30];
    assign rc[k][0] = gcb_pkg::rot_prep(ang[k], v3_q);
  end

  for (genvar k = 0; k < 3; k++) begin : g_rot
    for (genvar i = 0; i < N; i++) begin : g_cell
      gcb_rot_cell #(.STAGE(i)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .d_i    (rc[k][i]),
        .q_o    (rc[k][i+1])
      );
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (rc[k][N].zero) begin
        s_d[k] = '0;
        c_d[k] = gcb_pkg::Q_ONE;
      end else if (rc[k][N].neg) begin
        s_d[k] = -rc[k][N].y;
        c_d[k] = -rc[k][N].x;
      end else begin
        s_d[k] = rc[k][N].y;
        c_d[k] = rc[k][N].x;
      end
    end
  end

  // Q30 products: index 0 start latitude, 1 destination latitude, 2 longitude difference
  assign m_a1   = (2*gcb_pkg::XW)'(s_q[2]) * (2*gcb_pkg::XW)'(c_q[1]);
  assign m_c1s2 = (2*gcb_pkg::XW)'(c_q[0]) * (2*gcb_pkg::XW)'(s_q[1]);
  assign m_s1c2 = (2*gcb_pkg::XW)'(s_q[0]) * (2*gcb_pkg::XW)'(c_q[1]);
  assign m_t    = (gcb_pkg::QW+gcb_pkg::XW)'(s1c2_5_q)
                * (gcb_pkg::QW+gcb_pkg::XW)'(cd5_q);
  assign a2_6   = c1s2_6_q - t6_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s_q[k] <= s_d[k];
      c_q[k] <= c_d[k];
    end
    a1_5_q   <= gcb_pkg::QW'(m_a1 >>> 30);
    c1s2_5_q <= gcb_pkg::QW'(m_c1s2 >>> 30);
    s1c2_5_q <= gcb_pkg::QW'(m_s1c2 >>> 30);
    cd5_q    <= c_q[2];
    a1_6_q   <= a1_5_q;
    c1s2_6_q <= c1s2_5_q;
    t6_q     <= gcb_pkg::QW'(m_t >>> 30);
    a1_7_q   <= a1_6_q;
    a2_7_q   <= a2_6;
    z7_q     <= (a1_6_q == '0) && (a2_6 == '0);
  end

  always_comb begin
    vc[0].valid = v7_q;
    vc[0].zero  = z7_q;
    if (a2_7_q < 0) begin
      vc[0].x = -gcb_pkg::AW'(a2_7_q);
      vc[0].y = -gcb_pkg::AW'(a1_7_q);
      vc[0].z = gcb_pkg::HALF;
    end else begin
      vc[0].x = gcb_pkg::AW'(a2_7_q);
      vc[0].y = gcb_pkg::AW'(a1_7_q);
      vc[0].z = '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    gcb_vec_cell #(.STAGE(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .d_i    (vc[i]),
      .q_o    (vc[i+1])
    );
  end

  // scale to hundredths of a degree, round half up
  assign rnd = prod_q + gcb_pkg::OUT_RND;
  always_comb begin
    h = rnd[47:32];
    if (z8_q || (h >= gcb_pkg::FULL_TURN)) begin
      h = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= 48'(vc[N].z) * gcb_pkg::DEG_SCALE;
    z8_q      <= vc[N].zero;
    bearing_q <= h;
  end

  assign z4_q = 1'b0;
  assign z5_q = z4_q;
  assign z6_q = z5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      v8_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i & ~busy_o;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= rc[0][N].valid | z6_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      v8_q   <= vc[N].valid;
      done_q <= v8_q;
    end
  end

  assign done_o    = done_q;
  assign bearing_o = bearing_q;

endmodule
`default_nettype wire

@@ rtl/gcb_checker.sv @@
// Port-level checker for the bearing block, bound to the top level
`default_nettype none
`include "great_circle_bearing_top_assert.svh"
module gcb_checker #(
  parameter int unsigned STAGES = gcb_pkg::CORDIC_STAGES_DEF
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic [15:0] bearing_o
);

  localparam int unsigned LAT = 9 + 2 * STAGES;

  `GCB_ASSERT_IMP(a_range, done_o, bearing_o < gcb_pkg::FULL_TURN)
  `GCB_ASSERT_IMP(a_never_busy, 1'b1, !busy_o)
  `GCB_ASSERT_DLY(a_result_follows, start_i && !busy_o, LAT, done_o)
  `GCB_ASSERT_IMP(a_no_stray, done_o && rst_ni == $past(rst_ni, LAT), $past(start_i, LAT))

endmodule

bind great_circle_bearing_top gcb_checker #(.STAGES(CORDIC_STAGES)) u_gcb_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .done_o    (done_o),
  .bearing_o (bearing_o)
);
`default_nettype wire
